/* rtl/mme_pkg.sv */
// ----------------------------------------------------------------------------
// mme_pkg: shared types and codes of the matrix multiply engine
// Request and result payloads, command codes, register indexes and the
// control bundle that goes from the sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int PRODUCT_WIDTH = 36;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] REG_ROWS_A     = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [1:0] REG_COLS_B     = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic [2:0]         row;
		logic [2:0]         column;
		logic signed [15:0] value;
	} request_t;

	typedef struct packed {
		logic signed [PRODUCT_WIDTH-1:0] product;
		logic                            error;
	} result_t;

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctrl_t;

endpackage

/* rtl/matrix_multiply_engine_unit.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit: general matrix multiply, one product element
// per query
// Two element stores (A and B) are loaded one request at a time; a query
// sums inner_size products of one row of A and one column of B.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/request and are taken at an edge where start is
//   high and busy is low. Load A and load B write one Q8.8 element in the
//   cycle they are taken and give no result; busy stays low, so loads can
//   follow each other every cycle. Command 3 is dropped silently.
//   A query whose row or column lies outside the configured sizes returns
//   error with a zero product in the cycle after it is taken.
//   A valid query runs through the shared multiply-accumulate unit: one
//   store read per cycle over inner_size elements, then a drain through the
//   RAM read, product and accumulate registers, then the result with done.
//   Busy is high from acceptance until the done strobe, and no new request
//   is taken meanwhile; the inner-product loop through the one read port of
//   each store sets how long a query keeps it high.
//   Results appear on result for exactly one cycle, marked by done; the
//   receiver cannot hold them off, and none is kept afterwards.
//   The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is
//   always ready; write it only while no query is in flight.
//   Reset sets all three sizes to 8 and idles the sequencer; the stores hold
//   nothing defined until loaded.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_unit
	import mme_pkg::*;
#(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  request_t   request,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_DIM + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	localparam logic [4:0] MAX_DIM5 = 5'(MAX_DIM);
	localparam logic [5:0] MAX_DIM6 = 6'(MAX_DIM);

	// clamp a size register into 1..MAX_DIM
	function automatic logic [CW-1:0] dim_clamp(input logic [3:0] r);
		logic [4:0] d;
		d = {1'b0, r};
		if (d == 5'd0) begin
			d = 5'd1;
		end else if (d > MAX_DIM5) begin
			d = MAX_DIM5;
		end
		return CW'(d);
	endfunction

	logic [3:0] rows_a_q, inner_size_q, cols_b_q;
	logic [CW-1:0] n_dim, m_dim, k_dim, m_last;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] a_addr_q, b_addr_q;
	logic          rd_vld_q;
	logic          done_q;
	result_t       result_q;

	logic accept, is_load, load_ok, query_err, query_ok, issuing, mac_pending;
	logic [AW-1:0] load_addr;
	logic signed [ELEM_WIDTH-1:0] elem, a_rd, b_rd;
	logic signed [PRODUCT_WIDTH-1:0] acc;
	mac_ctrl_t mac_ctrl;

	// ---------------------------------------------------------------- config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= 4'd8;
			inner_size_q <= 4'd8;
			cols_b_q     <= 4'd8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS_A:     rows_a_q     <= cfg_data;
				REG_INNER_SIZE: inner_size_q <= cfg_data;
				REG_COLS_B:     cols_b_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_dim  = dim_clamp(rows_a_q);
	assign m_dim  = dim_clamp(inner_size_q);
	assign k_dim  = dim_clamp(cols_b_q);
	assign m_last = m_dim - CW'(1);

	// --------------------------------------------------------------- decode
	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_load = (request.command == CMD_LOAD_A) || (request.command == CMD_LOAD_B);

	// loads only check against the physical store, not the configured sizes
	assign load_ok = ({3'b000, request.row} < MAX_DIM6) &&
			({3'b000, request.column} < MAX_DIM6);
	assign load_addr = AW'(request.row) * AW'(MAX_DIM) + AW'(request.column);
	assign elem      = ELEM_WIDTH'(request.value);

	assign query_err = ({2'b00, request.row} >= 5'(n_dim)) ||
			({2'b00, request.column} >= 5'(k_dim));
	assign query_ok  = accept && (request.command == CMD_QUERY) && !query_err;

	assign issuing = (state_q == ST_ISSUE);

	// --------------------------------------------------------------- stores
	mme_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(DEPTH)
	) u_store_a (
		.clk  (clk),
		.we   (accept && is_load && load_ok && (request.command == CMD_LOAD_A)),
		.waddr(load_addr),
		.wdata(elem),
		.re   (issuing),
		.raddr(a_addr_q),
		.rdata(a_rd)
	);

	mme_ram #(
		.WIDTH(ELEM_WIDTH),
		.DEPTH(DEPTH)
	) u_store_b (
		.clk  (clk),
		.we   (accept && is_load && load_ok && (request.command == CMD_LOAD_B)),
		.waddr(load_addr),
		.wdata(elem),
		.re   (issuing),
		.raddr(b_addr_q),
		.rdata(b_rd)
	);

	// ------------------------------------------------------ multiply-accumulate
	assign mac_ctrl.clear = query_ok;
	assign mac_ctrl.valid = rd_vld_q;

	mme_mac #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a      (a_rd),
		.b      (b_rd),
		.pending(mac_pending),
		.acc    (acc)
	);

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			rd_vld_q <= issuing;
			done_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (query_ok) begin
						cnt_q   <= '0;
						state_q <= ST_ISSUE;
					end else if (accept && (request.command == CMD_QUERY)) begin
						// out-of-range query: answer at once with the error flag
						done_q <= 1'b1;
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == m_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// wait for the last term to land in the accumulator
					if (!rd_vld_q && !mac_pending) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// address walkers: A advances along the row, B down the column
	always_ff @(posedge clk) begin
		if (query_ok) begin
			a_addr_q <= AW'(request.row) * AW'(MAX_DIM);
			b_addr_q <= AW'(request.column);
		end else if (issuing) begin
			a_addr_q <= a_addr_q + AW'(1);
			b_addr_q <= b_addr_q + AW'(MAX_DIM);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			result_q.product <= acc;
			result_q.error   <= 1'b0;
		end else begin
			result_q.product <= '0;
			result_q.error   <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// ----------------------------------------------------------- assertions
	a_good_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.error |-> $past(state_q) == ST_DRAIN)
		else $error("good result without a drained accumulation");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error |-> $past(state_q) == ST_IDLE && result.product == '0)
		else $error("error result with nonzero product or mid-query");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> cnt_q < m_dim)
		else $error("issue counter ran past the inner size");

	a_mac_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_q || mac_pending) |-> state_q == ST_DRAIN || state_q == ST_ISSUE)
		else $error("accumulation in flight while idle");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |=> state_q != ST_IDLE)
		else $error("sequencer left issue without draining");

endmodule

/* rtl/mme_ram.sv */
// ----------------------------------------------------------------------------
// mme_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/mme_mac.sv */
// ----------------------------------------------------------------------------
// mme_mac: shared multiply-accumulate unit
// Registers one signed product per cycle, then adds it into a Q20.16
// accumulator that wraps at the product width.
// ----------------------------------------------------------------------------
module mme_mac
	import mme_pkg::*;
#(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mac_ctrl_t                       ctrl,
	input  logic signed [ELEM_WIDTH-1:0]    a,
	input  logic signed [ELEM_WIDTH-1:0]    b,
	output logic                            pending,
	output logic signed [PRODUCT_WIDTH-1:0] acc
);

	logic signed [2*ELEM_WIDTH-1:0] prod_s1;
	logic                           vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (ctrl.clear) begin
			acc <= '0;
		end else if (vld_s1) begin
			// sign-extend or wrap the term to the accumulator width
			acc <= acc + PRODUCT_WIDTH'(prod_s1);
		end
	end

	assign pending = vld_s1;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for matrix_multiply_engine_unit
// Loads elements of A and B, asks for product elements and checks every
// result against a typed-in value or a local inner-product predictor. A short
// table of directed requests comes first, then random traffic over several
// size settings, with random sender pauses that change every second block.
// ----------------------------------------------------------------------------
module tb;
	import mme_pkg::*;

	localparam int         DIM         = 8;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SETTLE      = 14;
	localparam int         BLOCKS      = 6;
	localparam int         BLOCK_ITEMS = 225;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	// One row of the directed table: a register write or a request, with the
	// expected result typed in when it is obvious from the math.
	typedef struct {
		bit         is_cfg;
		logic [1:0] idx;
		logic [3:0] data;
		request_t   req;
		bit         known;
		result_t    want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	request_t   request;
	logic       done;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	// Mirror of the block: raw size registers and both element stores.
	logic [3:0]         rows_reg, inner_reg, cols_reg;
	logic signed [15:0] elem_a [DIM*DIM];
	logic signed [15:0] elem_b [DIM*DIM];
	bit                 loaded_a [DIM*DIM];
	bit                 loaded_b [DIM*DIM];

	result_t pending_products[$];
	int      idle_pct;
	int      mismatches;
	int      cycles = 0;
	int      loads_taken, queries_taken, error_queries, dropped_taken, reg_writes;

	matrix_multiply_engine_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Hard stop if the block stalls or loses a strobe.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_products.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report(input string what);
		if (mismatches < 50)
			$display("mismatch @%0t: %s", $time, what);
		mismatches++;
	endtask

	// Results cannot be held off: check each strobe against the oldest entry.
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_products.size() == 0) begin
				report("result strobe with no query waiting");
			end else begin
				want = pending_products.pop_front();
				if (result.product !== want.product)
					report($sformatf("product %0d, want %0d", result.product, want.product));
				if (result.error !== want.error)
					report($sformatf("error %b, want %b", result.error, want.error));
			end
		end
	end

	// Size registers: zero counts as one, anything above the store size as eight.
	function automatic int eff_dim(input logic [3:0] raw);
		if (raw == 4'd0)
			return 1;
		if (raw > DIM)
			return DIM;
		return int'(raw);
	endfunction

	// Exact Q20.16 inner product of row r of A and column c of B.
	function automatic result_t product_element(input int r, input int c);
		longint  acc;
		result_t res;
		acc = 0;
		for (int k = 0; k < eff_dim(inner_reg); k++)
			acc += longint'(elem_a[r*DIM+k]) * longint'(elem_b[k*DIM+c]);
		res.product = acc[PRODUCT_WIDTH-1:0];
		res.error   = 1'b0;
		return res;
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [3:0] data);
		stim_row_t s;
		s        = '{default: '0};
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.data   = data;
		return s;
	endfunction

	function automatic stim_row_t req_row(input logic [1:0] cmd, input int r, input int c,
			input logic [15:0] val);
		stim_row_t s;
		s                = '{default: '0};
		s.req.command    = cmd;
		s.req.row        = 3'(r);
		s.req.column     = 3'(c);
		s.req.value      = val;
		return s;
	endfunction

	function automatic stim_row_t chk_row(input int r, input int c, input longint prod,
			input bit err);
		stim_row_t s;
		s              = req_row(CMD_QUERY, r, c, 16'h0);
		s.known        = 1'b1;
		s.want.product = prod[PRODUCT_WIDTH-1:0];
		s.want.error   = err;
		return s;
	endfunction

	// Drop start and wait until every query has returned, plus a margin for
	// anything still in the accumulate pipeline.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_ROWS_A:     rows_reg  = data;
			REG_INNER_SIZE: inner_reg = data;
			REG_COLS_B:     cols_reg  = data;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Present one request, maybe after a random pause, hold it until taken,
	// then update the mirror and queue the expected result of a query.
	task automatic issue(input request_t req, input bit known, input result_t want);
		int      gap;
		int      slot;
		result_t res;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);

		slot = int'(req.row) * DIM + int'(req.column);
		case (req.command)
			CMD_LOAD_A: begin
				elem_a[slot]   = req.value;
				loaded_a[slot] = 1'b1;
				loads_taken++;
			end
			CMD_LOAD_B: begin
				elem_b[slot]   = req.value;
				loaded_b[slot] = 1'b1;
				loads_taken++;
			end
			CMD_QUERY: begin
				if (req.row >= eff_dim(rows_reg) || req.column >= eff_dim(cols_reg)) begin
					res.product = '0;
					res.error   = 1'b1;
					error_queries++;
				end else begin
					res = product_element(int'(req.row), int'(req.column));
				end
				if (known)
					res = want;
				pending_products.push_back(res);
				queries_taken++;
			end
			default: dropped_taken++;
		endcase
	endtask

	task automatic run_table(input stim_row_t plan[$]);
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].data);
			else
				issue(plan[i].req, plan[i].known, plan[i].want);
		end
	endtask

	// Random traffic: loads, in-range queries with any missing elements loaded
	// first, out-of-range queries and the odd unused command.
	task automatic run_random(input int items);
		int       taken;
		int       roll;
		int       r, c;
		request_t req;
		result_t  none;
		none  = '0;
		taken = 0;
		while (taken < items) begin
			roll        = $urandom_range(99);
			req.row     = 3'($urandom_range(DIM - 1));
			req.column  = 3'($urandom_range(DIM - 1));
			req.value   = pick_value();
			if (roll < 30) begin
				req.command = CMD_LOAD_A;
			end else if (roll < 55) begin
				req.command = CMD_LOAD_B;
			end else if (roll < 95) begin
				req.command = CMD_QUERY;
				if ($urandom_range(99) < 85) begin
					req.row    = 3'($urandom_range(eff_dim(rows_reg) - 1));
					req.column = 3'($urandom_range(eff_dim(cols_reg) - 1));
				end
				r = int'(req.row);
				c = int'(req.column);
				// Never read an element that was not loaded: fill the row and
				// column that this query sums over.
				if (r < eff_dim(rows_reg) && c < eff_dim(cols_reg)) begin
					for (int k = 0; k < eff_dim(inner_reg); k++) begin
						if (!loaded_a[r*DIM+k]) begin
							issue('{CMD_LOAD_A, 3'(r), 3'(k), pick_value()}, 1'b0, none);
							taken++;
						end
						if (!loaded_b[k*DIM+c]) begin
							issue('{CMD_LOAD_B, 3'(k), 3'(c), pick_value()}, 1'b0, none);
							taken++;
						end
					end
				end
			end else begin
				req.command = CMD_UNUSED;
			end
			issue(req, 1'b0, none);
			if (req.command != CMD_UNUSED)
				taken++;
		end
	endtask

	initial begin
		stim_row_t directed[$];
		result_t   none;
		// Size settings per random block: extremes, out-of-range codes, mixes.
		logic [3:0] sched_rows  [BLOCKS];
		logic [3:0] sched_inner [BLOCKS];
		logic [3:0] sched_cols  [BLOCKS];

		sched_rows  = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd3, 4'd8};
		sched_inner = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd8};
		sched_cols  = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd6, 4'd4};

		none      = '0;
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROWS_A;
		cfg_data  = 4'd0;
		rows_reg  = 4'd8;
		inner_reg = 4'd8;
		cols_reg  = 4'd8;
		mismatches = 0;
		idle_pct  = 37;
		foreach (loaded_a[i]) begin
			loaded_a[i] = 1'b0;
			loaded_b[i] = 1'b0;
			elem_a[i]   = '0;
			elem_b[i]   = '0;
		end

		// Hold reset, then release it on a falling edge, away from the rising edge.
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: full-scale products, register clamping, errors, the
		// unused command. The checked sums of one term are typed in; the last query is predicted.
		directed.push_back(cfg_row(REG_INNER_SIZE, 4'd1));
		directed.push_back(cfg_row(REG_ROWS_A, 4'd0));                  // zero acts as one
		directed.push_back(cfg_row(REG_COLS_B, 4'd15));                 // clamps to eight
		directed.push_back(req_row(CMD_LOAD_A, 0, 0, 16'h7fff));
		directed.push_back(req_row(CMD_LOAD_B, 0, 0, 16'h7fff));
		directed.push_back(chk_row(0, 0, 64'sd1073676289, 1'b0));       // max * max
		directed.push_back(req_row(CMD_LOAD_A, 0, 0, 16'h8000));
		directed.push_back(chk_row(0, 0, -64'sd1073709056, 1'b0));      // min * max
		directed.push_back(req_row(CMD_LOAD_B, 0, 0, 16'h8000));
		directed.push_back(chk_row(0, 0, 64'sd1073741824, 1'b0));       // min * min
		directed.push_back(chk_row(1, 0, 0, 1'b1));                     // row out of range
		directed.push_back(chk_row(7, 7, 0, 1'b1));
		directed.push_back(req_row(CMD_LOAD_B, 0, 7, 16'h0100));         // 1.0
		directed.push_back(chk_row(0, 7, -64'sd8388608, 1'b0));
		directed.push_back(req_row(CMD_UNUSED, 7, 7, 16'hffff));         // dropped, no result
		directed.push_back(req_row(CMD_LOAD_A, 7, 7, 16'hffff));
		directed.push_back(req_row(CMD_LOAD_A, 7, 0, 16'hffff));         // -1/256
		directed.push_back(cfg_row(REG_ROWS_A, 4'd8));
		directed.push_back(chk_row(7, 0, 64'sd32768, 1'b0));
		directed.push_back(chk_row(7, 7, -64'sd256, 1'b0));
		directed.push_back(cfg_row(REG_COLS_B, 4'd1));
		directed.push_back(chk_row(0, 1, 0, 1'b1));                     // column out of range
		directed.push_back(req_row(CMD_QUERY, 0, 0, 16'h5a5a));
		directed.push_back(req_row(CMD_UNUSED, 0, 0, 16'h0000));
		run_table(directed);

		// Random part: two blocks per sender profile, each behind a full drain
		// and a fresh write of all three size registers.
		for (int b = 0; b < BLOCKS; b++) begin
			write_reg(REG_ROWS_A, sched_rows[b]);
			write_reg(REG_INNER_SIZE, sched_inner[b]);
			write_reg(REG_COLS_B, sched_cols[b]);
			idle_pct = (b < 2) ? 37 : (b < 4) ? 67 : 0;
			run_random(BLOCK_ITEMS);
		end

		// Drain and let the pipeline run dry before judging.
		settle();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d loads, %0d queries (%0d out of range), %0d unused commands",
			loads_taken, queries_taken, error_queries, dropped_taken);
		$display("over %0d register writes in %0d cycles, %0d mismatches",
			reg_writes, cycles, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
